// ----- design/iede_pkg.sv -----
// Shared types, constants and helper functions for the input event delta encoder.
package iede_pkg;

    // Record codes
    localparam logic [7:0] CODE_CHANGE_WIN = 8'h61;  // 'a'
    localparam logic [7:0] CODE_ZERO_MOVE  = 8'h62;  // 'b'
    localparam logic [7:0] CODE_BYTE_MOVE  = 8'h63;  // 'c'
    localparam logic [7:0] CODE_WORD_MOVE  = 8'h64;  // 'd'
    localparam logic [7:0] CODE_DELAY      = 8'h65;  // 'e'
    localparam logic [7:0] CODE_TYPE_BASE  = 8'h7A;  // 'z'
    localparam logic [7:0] MOVE_BIAS       = 8'h80;
    localparam logic [7:0] UNIT_LIMIT      = 8'd255;

    // Event type bits and timing scale
    localparam int KEY_TYPE_BIT    = 0;
    localparam int BUTTON_DOWN_BIT = 1;
    localparam int BUTTON_UP_BIT   = 2;
    localparam int TIME_SHIFT      = 17;

    // Field widths
    localparam int WIN_W   = 16;
    localparam int POS_W   = 16;
    localparam int TYPE_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int IDX_W   = $clog2(TYPE_W + 1);
    localparam int TDATA_W = 96;

    // Byte slots of a record, in emission order
    localparam int NUM_SLOTS = 12;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_DELAY_CODE = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_DELAY_UNIT = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_WIN_CODE   = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_WIN_LO     = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SLOT_WIN_HI     = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] SLOT_MOVE_CODE  = SLOT_W'(5);
    localparam logic [SLOT_W-1:0] SLOT_MOVE_0     = SLOT_W'(6);
    localparam logic [SLOT_W-1:0] SLOT_MOVE_1     = SLOT_W'(7);
    localparam logic [SLOT_W-1:0] SLOT_MOVE_2     = SLOT_W'(8);
    localparam logic [SLOT_W-1:0] SLOT_MOVE_3     = SLOT_W'(9);
    localparam logic [SLOT_W-1:0] SLOT_TYPE       = SLOT_W'(10);
    localparam logic [SLOT_W-1:0] SLOT_TAIL       = SLOT_W'(11);

    // Descriptor queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register map
    localparam int PADDR_W = 2;
    localparam logic [PADDR_W-1:0] ADDR_TIMING = PADDR_W'(0);

    // One classified event: which slots are present and their bytes
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [BYTE_W-1:0]    units;
        logic [WIN_W-1:0]     win;
        logic [BYTE_W-1:0]    move_code;
        logic [4*BYTE_W-1:0]  mv;
        logic [BYTE_W-1:0]    type_code;
        logic [BYTE_W-1:0]    tail;
    } t_desc;

    // Index of the lowest set bit of the type mask, TYPE_W when none
    function automatic logic [IDX_W-1:0] lowest_type_bit(input logic [TYPE_W-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(TYPE_W);
        for (int i = TYPE_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Lowest pending slot of a record
    function automatic logic [SLOT_W-1:0] lowest_slot(input logic [NUM_SLOTS-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    // Byte carried by a given slot
    function automatic logic [BYTE_W-1:0] slot_byte(input t_desc d,
                                                   input logic [SLOT_W-1:0] s);
        logic [BYTE_W-1:0] b;
        unique case (s)
            SLOT_DELAY_CODE: b = CODE_DELAY;
            SLOT_DELAY_UNIT: b = d.units;
            SLOT_WIN_CODE:   b = CODE_CHANGE_WIN;
            SLOT_WIN_LO:     b = d.win[7:0];
            SLOT_WIN_HI:     b = d.win[15:8];
            SLOT_MOVE_CODE:  b = d.move_code;
            SLOT_MOVE_0:     b = d.mv[7:0];
            SLOT_MOVE_1:     b = d.mv[15:8];
            SLOT_MOVE_2:     b = d.mv[23:16];
            SLOT_MOVE_3:     b = d.mv[31:24];
            SLOT_TYPE:       b = d.type_code;
            SLOT_TAIL:       b = d.tail;
            default:         b = '0;
        endcase
        return b;
    endfunction

endpackage

// ----- design/iede_front.sv -----
// Front end: holds the previous-event state and classifies each event into a descriptor.
module iede_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_timing_en,
    input  logic [iede_pkg::WIN_W-1:0]    i_window_id,
    input  logic [iede_pkg::POS_W-1:0]    i_pos_x,
    input  logic [iede_pkg::POS_W-1:0]    i_pos_y,
    input  logic [iede_pkg::TYPE_W-1:0]   i_event_type,
    input  logic [iede_pkg::BYTE_W-1:0]   i_key_char,
    input  logic [iede_pkg::BYTE_W-1:0]   i_button_flags,
    input  logic [iede_pkg::TIME_W-1:0]   i_timestamp_us,
    output iede_pkg::t_desc               o_desc
);
    import iede_pkg::*;

    logic [WIN_W-1:0]  r_prev_win;
    logic [POS_W-1:0]  r_prev_x;
    logic [POS_W-1:0]  r_prev_y;
    logic [TIME_W-1:0] r_prev_time;
    logic              r_time_valid;

    logic [TIME_W-1:0]            elapsed;
    logic [TIME_W-TIME_SHIFT-1:0] unit_raw;
    logic [BYTE_W-1:0]            units;
    logic                         has_delay;
    logic                         win_change;
    logic [POS_W:0]               dx;
    logic [POS_W:0]               dy;
    logic                         still;
    logic                         byte_fit;
    logic [IDX_W-1:0]             type_idx;
    logic                         is_key;
    logic                         is_button;

    // Elapsed time in scaled units, saturated to one byte
    always_comb begin
        elapsed  = i_timestamp_us - r_prev_time;
        unit_raw = elapsed[TIME_W-1:TIME_SHIFT];
        if (unit_raw > (TIME_W-TIME_SHIFT)'(UNIT_LIMIT)) begin
            units = UNIT_LIMIT;
        end else begin
            units = unit_raw[BYTE_W-1:0];
        end
        has_delay = i_timing_en && r_time_valid && (unit_raw != '0);
    end

    // Position deltas and their encoding form
    always_comb begin
        dx         = {i_pos_x[POS_W-1], i_pos_x} - {r_prev_x[POS_W-1], r_prev_x};
        dy         = {i_pos_y[POS_W-1], i_pos_y} - {r_prev_y[POS_W-1], r_prev_y};
        still      = (dx == '0) && (dy == '0);
        // delta lies in -128..127 when its top bits are all copies of bit 7
        byte_fit   = ((dx[POS_W:7] == '0) || (dx[POS_W:7] == '1)) &&
                     ((dy[POS_W:7] == '0) || (dy[POS_W:7] == '1));
        win_change = (i_window_id != r_prev_win);
        type_idx   = lowest_type_bit(i_event_type);
        is_key     = (i_event_type == TYPE_W'(1) << KEY_TYPE_BIT);
        is_button  = (i_event_type == TYPE_W'(1) << BUTTON_DOWN_BIT) ||
                     (i_event_type == TYPE_W'(1) << BUTTON_UP_BIT);
    end

    // Descriptor assembly
    always_comb begin
        o_desc           = '0;
        o_desc.units     = units;
        o_desc.win       = i_window_id;
        o_desc.type_code = CODE_TYPE_BASE + BYTE_W'(type_idx);
        o_desc.tail      = is_key ? i_key_char : i_button_flags;

        o_desc.mask[SLOT_DELAY_CODE] = has_delay;
        o_desc.mask[SLOT_DELAY_UNIT] = has_delay;
        o_desc.mask[SLOT_WIN_CODE]   = win_change;
        o_desc.mask[SLOT_WIN_LO]     = win_change;
        o_desc.mask[SLOT_WIN_HI]     = win_change;
        o_desc.mask[SLOT_MOVE_CODE]  = 1'b1;
        o_desc.mask[SLOT_TYPE]       = 1'b1;
        o_desc.mask[SLOT_TAIL]       = is_key || is_button;

        priority if (still) begin
            o_desc.move_code = CODE_ZERO_MOVE;
        end else if (byte_fit) begin
            o_desc.move_code          = CODE_BYTE_MOVE;
            o_desc.mv[7:0]            = dx[7:0] ^ MOVE_BIAS;
            o_desc.mv[15:8]           = dy[7:0] ^ MOVE_BIAS;
            o_desc.mask[SLOT_MOVE_0]  = 1'b1;
            o_desc.mask[SLOT_MOVE_1]  = 1'b1;
        end else begin
            o_desc.move_code          = CODE_WORD_MOVE;
            o_desc.mv                 = {dy[POS_W-1:0], dx[POS_W-1:0]};
            o_desc.mask[SLOT_MOVE_0]  = 1'b1;
            o_desc.mask[SLOT_MOVE_1]  = 1'b1;
            o_desc.mask[SLOT_MOVE_2]  = 1'b1;
            o_desc.mask[SLOT_MOVE_3]  = 1'b1;
        end
    end

    // Previous-event state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_win   <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_time  <= '0;
            r_time_valid <= 1'b0;
        end else if (i_accept) begin
            r_prev_win <= i_window_id;
            r_prev_x   <= i_pos_x;
            r_prev_y   <= i_pos_y;
            if (i_timing_en) begin
                r_prev_time  <= i_timestamp_us;
                r_time_valid <= 1'b1;
            end
        end
    end

endmodule

// ----- design/iede_queue.sv -----
// Short descriptor queue between the front end and the byte serialiser.
module iede_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  iede_pkg::t_desc i_desc,
    input  logic            i_pop,
    output iede_pkg::t_desc o_head,
    output logic            o_full,
    output logic            o_empty
);
    import iede_pkg::*;

    t_desc             r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head  = r_slot[r_rd_ptr];
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// ----- design/iede_back.sv -----
// Back end: walks each descriptor's present slots, one byte a cycle unless stalled.
module iede_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  iede_pkg::t_desc             i_head,
    output logic                        o_pop,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [iede_pkg::BYTE_W-1:0] o_m_tdata,
    output logic                        o_m_tlast
);
    import iede_pkg::*;

    t_desc                r_cur;
    logic [NUM_SLOTS-1:0] r_mask;
    logic                 r_ovalid;
    logic [BYTE_W-1:0]    r_odata;
    logic                 r_olast;

    logic                 from_q;
    t_desc                src;
    logic [NUM_SLOTS-1:0] src_mask;
    logic [NUM_SLOTS-1:0] rest;
    logic [SLOT_W-1:0]    slot;
    logic                 adv;

    // Pick the record being walked: the held one, else the queue head
    always_comb begin
        from_q   = (r_mask == '0);
        src      = from_q ? i_head : r_cur;
        src_mask = from_q ? (i_empty ? '0 : i_head.mask) : r_mask;
        rest     = src_mask & (src_mask - 1'b1);
        slot     = lowest_slot(src_mask);
        adv      = !r_ovalid || i_m_tready;
        o_pop    = adv && from_q && !i_empty;
    end

    // Control: pending slots and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= (src_mask != '0);
            r_mask   <= rest;
        end
    end

    // Payload: output word and held descriptor
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_odata <= slot_byte(src, slot);
            r_olast <= (rest == '0);
            if (o_pop) begin
                r_cur <= i_head;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

endmodule

// ----- design/input_event_delta_encoder.sv -----
// Top level of the input event delta encoder: stream ports, configuration register, datapath.
// Each accepted event word becomes a record of 2 to 12 bytes on the master stream, one byte
// per cycle while the receiver is ready, tlast on the final byte. The front end classifies
// an event in the cycle it is accepted and may take a new one every cycle while the two-entry
// descriptor queue has room; sustained throughput is set by the byte serialiser. Records
// follow each other back to back while the queue holds a descriptor and the receiver is ready.
// The timing_enable register sits at byte address 0 and resets to 1.
module input_event_delta_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [iede_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [31:0]                   i_pwdata,
    output logic [31:0]                   o_prdata,
    output logic                          o_pready,
    // event input
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // window_id[15:0], pos_x[31:16], pos_y[47:32], key_char[55:48],
    // button_flags[63:56], timestamp_us[95:64]
    input  logic [iede_pkg::TDATA_W-1:0]  i_s_tdata,
    // event_type[15:0]
    input  logic [iede_pkg::TYPE_W-1:0]   i_s_tuser,
    // record output
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // out_byte[7:0]
    output logic [iede_pkg::BYTE_W-1:0]   o_m_tdata,
    output logic                          o_m_tlast
);
    import iede_pkg::*;

    logic  r_timing_en;
    logic  accept;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    t_desc new_desc;
    t_desc head_desc;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing_en <= 1'b1;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr == ADDR_TIMING)) begin
            r_timing_en <= i_pwdata[0];
        end
    end

    assign o_pready   = 1'b1;
    assign o_prdata   = (i_paddr == ADDR_TIMING) ? {31'b0, r_timing_en} : '0;
    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && !q_full;

    iede_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_timing_en    (r_timing_en),
        .i_window_id    (i_s_tdata[15:0]),
        .i_pos_x        (i_s_tdata[31:16]),
        .i_pos_y        (i_s_tdata[47:32]),
        .i_event_type   (i_s_tuser),
        .i_key_char     (i_s_tdata[55:48]),
        .i_button_flags (i_s_tdata[63:56]),
        .i_timestamp_us (i_s_tdata[95:64]),
        .o_desc         (new_desc)
    );

    iede_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_desc  (new_desc),
        .i_pop   (q_pop),
        .o_head  (head_desc),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    iede_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_head     (head_desc),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the input event delta encoder: random and directed events, byte checks.
`timescale 1ns / 100ps

module tb;
    import iede_pkg::*;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no word moving on either stream
    localparam int RAND_PHASES  = 6;
    localparam int RAND_PER_PH  = 45;
    localparam int BIAS         = int'(MOVE_BIAS);
    localparam logic [31:0] TICK = 32'd1 << TIME_SHIFT;

    // one input event as the generator sees it
    typedef struct packed {
        logic [WIN_W-1:0]  win;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [TYPE_W-1:0] kind;
        logic [BYTE_W-1:0] key;
        logic [BYTE_W-1:0] flags;
        logic [TIME_W-1:0] ts;
    } t_ui_event;

    // one expected record byte
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_rec_byte;

    // idling modes: none, sender idle, receiver stalling, both
    localparam int SEND_PCT [4] = '{0, 70, 0, 22};
    localparam int RECV_PCT [4] = '{0, 0, 70, 22};

    logic                i_clk;
    logic                rst_n    = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         o_prdata;
    logic                o_pready;
    logic                s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic [TYPE_W-1:0]   s_tuser  = '0;
    logic                o_m_tvalid;
    logic                m_tready = 1'b0;
    logic [BYTE_W-1:0]   o_m_tdata;
    logic                o_m_tlast;

    t_ui_event pending_q [$];
    t_rec_byte record_q  [$];
    int        mismatches  = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    // encoder state as predicted
    logic              timing_on = 1'b1;
    logic [WIN_W-1:0]  last_win  = '0;
    logic [POS_W-1:0]  last_x    = '0;
    logic [POS_W-1:0]  last_y    = '0;
    logic [TIME_W-1:0] last_ts   = '0;
    logic              ts_seen   = 1'b0;

    // generator's view of the last queued event
    logic [WIN_W-1:0]  gen_win = '0;
    logic [POS_W-1:0]  gen_x   = '0;
    logic [POS_W-1:0]  gen_y   = '0;
    logic [TIME_W-1:0] gen_ts  = '0;

    input_event_delta_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        // window_id[15:0], pos_x[31:16], pos_y[47:32], key_char[55:48],
        // button_flags[63:56], timestamp_us[95:64]
        .i_s_tdata  (s_tdata),
        // event_type[15:0]
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        // out_byte[7:0]
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Work out the record bytes of one accepted event and advance the state
    task automatic encode_record(input t_ui_event ev);
        logic [BYTE_W-1:0] rec [$];
        logic [31:0]       units;
        int                dx;
        int                dy;
        int                idx;
        t_rec_byte         rb;
        // delay code
        if (timing_on) begin
            if (ts_seen) begin
                units = (ev.ts - last_ts) >> TIME_SHIFT;
                if (units > UNIT_LIMIT) begin
                    units = UNIT_LIMIT;
                end
                if (units != 0) begin
                    rec.push_back(CODE_DELAY);
                    rec.push_back(units[7:0]);
                end
            end
            last_ts = ev.ts;
            ts_seen = 1'b1;
        end
        // window change
        if (ev.win != last_win) begin
            rec.push_back(CODE_CHANGE_WIN);
            rec.push_back(ev.win[7:0]);
            rec.push_back(ev.win[15:8]);
        end
        last_win = ev.win;
        // motion
        if (ev.pos_x == last_x && ev.pos_y == last_y) begin
            rec.push_back(CODE_ZERO_MOVE);
        end else begin
            dx = $signed(ev.pos_x) - $signed(last_x);
            dy = $signed(ev.pos_y) - $signed(last_y);
            if (dx >= -BIAS && dx < BIAS && dy >= -BIAS && dy < BIAS) begin
                rec.push_back(CODE_BYTE_MOVE);
                rec.push_back(8'(dx + BIAS));
                rec.push_back(8'(dy + BIAS));
            end else begin
                rec.push_back(CODE_WORD_MOVE);
                rec.push_back(dx[7:0]);
                rec.push_back(dx[15:8]);
                rec.push_back(dy[7:0]);
                rec.push_back(dy[15:8]);
            end
            last_x = ev.pos_x;
            last_y = ev.pos_y;
        end
        // type code, then key or button byte
        idx = 0;
        while (idx < TYPE_W && !ev.kind[idx]) begin
            idx++;
        end
        rec.push_back(CODE_TYPE_BASE + 8'(idx));
        if (ev.kind == (16'd1 << KEY_TYPE_BIT)) begin
            rec.push_back(ev.key);
        end else if (ev.kind == (16'd1 << BUTTON_DOWN_BIT) ||
                     ev.kind == (16'd1 << BUTTON_UP_BIT)) begin
            rec.push_back(ev.flags);
        end
        foreach (rec[i]) begin
            rb.data = rec[i];
            rb.last = (i == rec.size() - 1);
            record_q.push_back(rb);
        end
    endtask

    task automatic add_event(input logic [WIN_W-1:0] win, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [TYPE_W-1:0] kind,
                             input logic [BYTE_W-1:0] key, input logic [BYTE_W-1:0] flags,
                             input logic [TIME_W-1:0] ts);
        t_ui_event ev;
        ev = '{win: win, pos_x: x, pos_y: y, kind: kind, key: key, flags: flags, ts: ts};
        pending_q.push_back(ev);
        gen_win = win;
        gen_x   = x;
        gen_y   = y;
        gen_ts  = ts;
    endtask

    // Random event, mostly realistic: same window, small moves, modest delays
    task automatic add_random_event();
        logic [WIN_W-1:0]  win;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [TYPE_W-1:0] kind;
        logic [TIME_W-1:0] gap;
        int                r;
        r = $urandom_range(99);
        if (r < 80) win = gen_win;
        else if (r < 88) win = 16'($urandom);
        else if (r < 94) win = '0;
        else win = '1;
        r = $urandom_range(99);
        if (r < 25) begin
            x = gen_x;
            y = gen_y;
        end else if (r < 75) begin
            x = gen_x + 16'(int'($urandom_range(260)) - 130);
            y = gen_y + 16'(int'($urandom_range(260)) - 130);
        end else begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
        r = $urandom_range(99);
        if (r < 25) kind = 16'd1 << KEY_TYPE_BIT;
        else if (r < 45) kind = 16'd1 << BUTTON_DOWN_BIT;
        else if (r < 65) kind = 16'd1 << BUTTON_UP_BIT;
        else if (r < 85) kind = 16'd1 << $urandom_range(TYPE_W - 1);
        else kind = 16'($urandom_range(65535, 1));
        r = $urandom_range(99);
        if (r < 15) gap = 32'($urandom_range(TICK - 1));
        else if (r < 65) gap = 32'($urandom_range(40, 1)) * TICK + 32'($urandom_range(TICK - 1));
        else if (r < 80) gap = 32'($urandom_range(255, 1)) * TICK;
        else if (r < 90) gap = $urandom;
        else gap = '0;
        add_event(win, x, y, kind, 8'($urandom), 8'($urandom), gen_ts + gap);
    endtask

    // Extremes of every field and each special case of the record format
    task automatic load_directed();
        add_event(16'h0000, 0, 0, 16'h0001, 8'h00, 8'h00, 32'h0000_0000);
        add_event(16'h0000, 0, 0, 16'h0002, 8'h5A, 8'hFF, 32'h0001_FFFF);
        add_event(16'hFFFF, 127, -128, 16'h0004, 8'h00, 8'hA5, 32'h0003_FFFF);
        add_event(16'hFFFF, -1, -1, 16'h0008, 8'hFF, 8'h00, 32'h0201_FFFF);
        add_event(16'h0001, 127, -1, 16'h8000, 8'h3C, 8'hC3, 32'h0401_FFFF);
        add_event(16'h0001, -2, -130, 16'hFFFF, 8'h11, 8'h22, 32'h0401_FFFF);
        add_event(16'h0000, -32768, 32767, 16'h0003, 8'h7F, 8'h80, 32'hFFFF_FFFF);
        // timestamp wraps past zero, wide deltas keep only their low 16 bits
        add_event(16'h0000, 32767, -32768, 16'h0006, 8'h01, 8'h02, 32'h0002_0000);
        // zero type mask
        add_event(16'h0000, 32767, -32768, 16'h0000, 8'hAA, 8'h55, 32'h0002_0000);
        add_event(16'h1234, 32762, -32761, 16'h0001, 8'hFF, 8'h00, 32'h0004_1234);
        add_event(16'h1234, 32762, -32761, 16'h0002, 8'h00, 8'h00, 32'h0005_0000);
        add_event(16'h1234, 32760, -32760, 16'h0004, 8'h81, 8'h81, 32'h8000_0000);
        add_event(16'h00FF, 0, 0, 16'h0010, 8'h00, 8'h00, 32'h8000_0001);
        add_event(16'hFF00, 128, 127, 16'h0100, 8'h00, 8'hFF, 32'h8040_0000);
        add_event(16'hFF00, 0, 255, 16'h0001, 8'h80, 8'h00, 32'h8040_0000);
    endtask

    // APB write: setup then access, completes on the edge with pready high
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        data = o_prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every queued event is sent and every record byte has come back
    task automatic wait_idle(input int tail_cycles);
        while (pending_q.size() != 0 || s_tvalid || record_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (tail_cycles) @(posedge i_clk);
    endtask

    // Event driver: one word per handshake on the slave stream
    always @(posedge i_clk) begin : event_driver
        t_ui_event ev;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                encode_record(ev);
            end
            if (!s_tvalid || o_s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    ev = pending_q.pop_front();
                    s_tdata  <= {ev.ts, ev.flags, ev.key, ev.pos_y, ev.pos_x, ev.win};
                    s_tuser  <= ev.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Record monitor: checks each byte word against the oldest expectation
    always @(posedge i_clk) begin : record_monitor
        t_rec_byte want;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (rst_n && o_m_tvalid && m_tready) begin
            if (record_q.size() == 0) begin
                report($sformatf("unexpected byte %02h last %0b", o_m_tdata, o_m_tlast));
            end else begin
                want = record_q.pop_front();
                if (o_m_tdata !== want.data) begin
                    report($sformatf("byte %02h, expected %02h", o_m_tdata, want.data));
                end
                if (o_m_tlast !== want.last) begin
                    report($sformatf("tlast %0b, expected %0b", o_m_tlast, want.last));
                end
            end
        end
    end

    // Watchdog on a stuck stream
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Sequence of phases
    initial begin : sequencer
        logic [31:0] rd;
        logic        en;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed events with timing at its reset value
        load_directed();
        wait_idle(4);

        // random phases, alternating timing and stepping through the idling modes
        for (int p = 0; p < RAND_PHASES; p++) begin
            en = p[0];
            apb_write(ADDR_TIMING, {31'd0, en});
            timing_on = en;
            apb_read(ADDR_TIMING, rd);
            if (rd !== {31'd0, en}) begin
                report($sformatf("timing_enable reads %08h, expected %0b", rd, en));
            end
            send_idle_pct  = SEND_PCT[p % 4];
            recv_stall_pct = RECV_PCT[p % 4];
            repeat (RAND_PER_PH) add_random_event();
            wait_idle(4);
        end

        wait_idle(2 * NUM_SLOTS);
        if (record_q.size() != 0) begin
            report($sformatf("%0d record bytes never arrived", record_q.size()));
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
